@@ sv/ptlex_pkg.sv @@
package ptlex_pkg;

    // Lexer modes
    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_IDENT = 4'd1,
        M_ZERO  = 4'd2,
        M_INT   = 4'd3,
        M_HEX   = 4'd4,
        M_FRAC  = 4'd5,
        M_EXP0  = 4'd6,
        M_EXPD  = 4'd7,
        M_STR   = 4'd8,
        M_ESC   = 4'd9
    } t_mode;

    // Token kinds
    localparam logic [3:0] K_EOF    = 4'd0;
    localparam logic [3:0] K_ID     = 4'd1;
    localparam logic [3:0] K_INT    = 4'd2;
    localparam logic [3:0] K_FLOAT  = 4'd3;
    localparam logic [3:0] K_STR    = 4'd4;
    localparam logic [3:0] K_EQ     = 4'd5;
    localparam logic [3:0] K_SLASH  = 4'd6;
    localparam logic [3:0] K_QUEST  = 4'd7;
    localparam logic [3:0] K_AMP    = 4'd8;
    localparam logic [3:0] K_LBRK   = 4'd9;
    localparam logic [3:0] K_RBRK   = 4'd10;
    localparam logic [3:0] K_MINUS  = 4'd11;
    localparam logic [3:0] K_COMMA  = 4'd12;
    localparam logic [3:0] K_ERR    = 4'd13;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UE     = 8'h45;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LE     = 8'h65;
    localparam logic [7:0] CH_LF_A   = 8'h66;
    localparam logic [7:0] CH_LN     = 8'h6E;
    localparam logic [7:0] CH_LX     = 8'h78;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    // Most results one character can cause
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [7:0] in_char;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic       is_done;
        logic [3:0] token_kind;
        logic [7:0] text_byte;
        logic       last_result;
    } t_res;

    // Decoder output: compacted result list, count and next mode
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         count;
        t_mode              next_mode;
    } t_step;

endpackage

@@ sv/ptlex_step.sv @@
module ptlex_step
    import ptlex_pkg::*;
(
    input  t_mode i_mode,
    input  t_in   i_in,
    output t_step o_step
);

    function automatic logic f_digit(input logic [7:0] c);
        f_digit = (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic f_alpha(input logic [7:0] c);
        f_alpha = ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ))
                  || (c == CH_UNDER);
    endfunction

    function automatic logic f_hex(input logic [7:0] c);
        f_hex = f_digit(c) || ((c >= CH_LA) && (c <= CH_LF_A))
                || ((c >= CH_UA) && (c <= CH_UF));
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        f_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic [3:0] f_kind(input t_mode m);
        case (m)
            M_IDENT:                  f_kind = K_ID;
            M_ZERO, M_INT, M_HEX:     f_kind = K_INT;
            M_FRAC, M_EXP0, M_EXPD:   f_kind = K_FLOAT;
            default:                  f_kind = K_STR;
        endcase
    endfunction

    // Next number mode, M_IDLE when the character ends the number
    function automatic t_mode f_num_next(input t_mode m, input logic [7:0] c);
        logic e;
        e = (c == CH_LE) || (c == CH_UE);
        case (m)
            M_ZERO: begin
                if (c == CH_LX)         f_num_next = M_HEX;
                else if (f_digit(c))    f_num_next = M_INT;
                else if (c == CH_DOT)   f_num_next = M_FRAC;
                else if (e)             f_num_next = M_EXP0;
                else                    f_num_next = M_IDLE;
            end
            M_INT: begin
                if (f_digit(c))         f_num_next = M_INT;
                else if (c == CH_DOT)   f_num_next = M_FRAC;
                else if (e)             f_num_next = M_EXP0;
                else                    f_num_next = M_IDLE;
            end
            M_HEX:  f_num_next = f_hex(c) ? M_HEX : M_IDLE;
            M_FRAC: begin
                if (f_digit(c))         f_num_next = M_FRAC;
                else if (e)             f_num_next = M_EXP0;
                else                    f_num_next = M_IDLE;
            end
            M_EXP0: f_num_next = ((c == CH_MINUS) || f_digit(c)) ? M_EXPD : M_IDLE;
            M_EXPD: f_num_next = f_digit(c) ? M_EXPD : M_IDLE;
            default: f_num_next = M_IDLE;
        endcase
    endfunction

    function automatic t_res f_text(input logic [7:0] b);
        t_res r;
        r.is_done     = 1'b0;
        r.token_kind  = K_EOF;
        r.text_byte   = b;
        r.last_result = 1'b0;
        f_text = r;
    endfunction

    function automatic t_res f_done(input logic [3:0] k, input logic [7:0] b);
        t_res r;
        r.is_done     = 1'b1;
        r.token_kind  = k;
        r.text_byte   = b;
        r.last_result = 1'b0;
        f_done = r;
    endfunction

    logic [7:0] c;
    logic       end_now;

    // start of a new token from c
    logic       s_v;
    t_res       s_r;
    t_mode      s_mode;

    // result slots in output order: close, char result, end close, eof
    logic [MAX_RES-1:0] v;
    t_res               r [MAX_RES];
    t_mode              mode_a;
    t_mode              mode_n;
    t_mode              nm;

    t_res [MAX_RES-1:0] list;
    logic [2:0]         cnt;

    assign c       = i_in.in_char;
    assign end_now = (c == CH_NUL) || i_in.end_of_input;
    assign nm      = f_num_next(i_mode, c);

    // token start
    always_comb begin
        s_v    = 1'b1;
        s_r    = f_done(K_ERR, c);
        s_mode = M_IDLE;
        if (f_space(c)) begin
            s_v = 1'b0;
        end else if (f_alpha(c)) begin
            s_r    = f_text(c);
            s_mode = M_IDENT;
        end else if (f_digit(c)) begin
            s_r    = f_text(c);
            s_mode = (c == CH_0) ? M_ZERO : M_INT;
        end else begin
            case (c)
                CH_QUOTE: begin
                    s_v    = 1'b0;
                    s_mode = M_STR;
                end
                CH_EQ:    s_r = f_done(K_EQ, 8'h00);
                CH_SLASH: s_r = f_done(K_SLASH, 8'h00);
                CH_QUEST: s_r = f_done(K_QUEST, 8'h00);
                CH_AMP:   s_r = f_done(K_AMP, 8'h00);
                CH_LBRK:  s_r = f_done(K_LBRK, 8'h00);
                CH_RBRK:  s_r = f_done(K_RBRK, 8'h00);
                CH_MINUS: s_r = f_done(K_MINUS, 8'h00);
                CH_COMMA: s_r = f_done(K_COMMA, 8'h00);
                default:  s_r = f_done(K_ERR, c);
            endcase
        end
    end

    // character step, then end-of-text closing
    always_comb begin
        v      = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            r[i] = f_text(8'h00);
        end
        mode_a = i_mode;
        if (c != CH_NUL) begin
            case (i_mode)
                M_IDENT: begin
                    if (f_alpha(c) || f_digit(c)) begin
                        v[1] = 1'b1;
                        r[1] = f_text(c);
                    end else begin
                        v[0]   = 1'b1;
                        r[0]   = f_done(K_ID, 8'h00);
                        v[1]   = s_v;
                        r[1]   = s_r;
                        mode_a = s_mode;
                    end
                end
                M_ZERO, M_INT, M_HEX, M_FRAC, M_EXP0, M_EXPD: begin
                    if (nm != M_IDLE) begin
                        v[1]   = 1'b1;
                        r[1]   = f_text(c);
                        mode_a = nm;
                    end else begin
                        v[0]   = 1'b1;
                        r[0]   = f_done(f_kind(i_mode), 8'h00);
                        v[1]   = s_v;
                        r[1]   = s_r;
                        mode_a = s_mode;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        v[1]   = 1'b1;
                        r[1]   = f_done(K_STR, 8'h00);
                        mode_a = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_a = M_ESC;
                    end else begin
                        v[1] = 1'b1;
                        r[1] = f_text(c);
                    end
                end
                M_ESC: begin
                    v[1]   = 1'b1;
                    r[1]   = f_text((c == CH_LN) ? CH_LF : c);
                    mode_a = M_STR;
                end
                default: begin
                    v[1]   = s_v;
                    r[1]   = s_r;
                    mode_a = s_mode;
                end
            endcase
        end
        mode_n = mode_a;
        if (end_now) begin
            if (mode_a != M_IDLE) begin
                v[2] = 1'b1;
                r[2] = f_done(f_kind(mode_a), 8'h00);
            end
            v[3]   = 1'b1;
            r[3]   = f_done(K_EOF, 8'h00);
            mode_n = M_IDLE;
        end
    end

    // pack valid slots to the front and flag the final one
    always_comb begin
        list = '0;
        cnt  = 3'd0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (v[i]) begin
                list[cnt[1:0]] = r[i];
                cnt            = cnt + 3'd1;
            end
        end
        for (int j = 0; j < MAX_RES; j++) begin
            if (3'(j) == cnt - 3'd1) begin
                list[j].last_result = 1'b1;
            end
        end
        o_step.res       = list;
        o_step.count     = cnt;
        o_step.next_mode = mode_n;
    end

endmodule

@@ sv/path_token_lexer.sv @@
// Path text tokenizer.
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one character word
// per handshake; a NUL character or end_of_input closes any open token and
// adds an EOF token. Output channel (o_out_valid / i_out_ready / o_out_word)
// gives one result word per handshake: token text bytes and token-done words,
// with last_result set on the final word a character caused.
// A character lands in the input register, is decoded into the result buffer
// once the buffer is free, and its first result is shown from the buffer.
// Throughput: one character per cycle while each character makes at most one
// result and the receiver does not stall; a character making several results
// holds the buffer until each has been drained, one per handshake, through
// the single output port. Characters that make no result (such as skipped
// whitespace) never occupy the result buffer.
// Reset (synchronous, active low) empties the input register and result
// buffer and returns the lexer to the between-tokens state.
// When the receiver stalls, the buffered results hold, the input register
// keeps one further character, and o_in_ready drops until the buffer frees.
module path_token_lexer
    import ptlex_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_word,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_res o_out_word
);

    logic       r_in_valid, n_in_valid;
    t_in        r_in, n_in;
    t_mode      r_mode, n_mode;
    t_res       r_res [MAX_RES];
    t_res       n_res [MAX_RES];
    logic [2:0] r_rem, n_rem;
    logic [1:0] r_idx, n_idx;

    t_step      step;
    logic       out_fire;
    logic       buf_free;
    logic       in_take;

    ptlex_step u_step (
        .i_mode (r_mode),
        .i_in   (r_in),
        .o_step (step)
    );

    // handshake
    assign o_out_valid = (r_rem != 3'd0);
    assign o_out_word  = r_res[r_idx];
    assign out_fire    = o_out_valid && i_out_ready;
    assign buf_free    = (r_rem == 3'd0) || ((r_rem == 3'd1) && out_fire);
    assign in_take     = r_in_valid && buf_free;
    assign o_in_ready  = !r_in_valid || buf_free;

    // next state
    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        n_mode     = r_mode;
        n_rem      = r_rem;
        n_idx      = r_idx;
        n_res      = r_res;
        if (out_fire) begin
            n_rem = r_rem - 3'd1;
            n_idx = r_idx + 2'd1;
        end
        if (in_take) begin
            n_in_valid = 1'b0;
            n_mode     = step.next_mode;
            n_rem      = step.count;
            n_idx      = 2'd0;
            for (int i = 0; i < MAX_RES; i++) begin
                n_res[i] = step.res[i];
            end
        end
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
            n_in       = i_in_word;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_rem      <= 3'd0;
            r_idx      <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_mode     <= n_mode;
            r_rem      <= n_rem;
            r_idx      <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_res <= n_res;
    end

    // checks
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= 3'd4)
        else $error("result buffer count out of range");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.last_result == (r_rem == 3'd1)))
        else $error("last_result does not match buffer drain");

    a_eof_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (r_in.end_of_input || (r_in.in_char == CH_NUL)))
        |=> (r_mode == M_IDLE))
        else $error("lexer not idle after end of text");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && (step.count != 3'd0)) |=> (r_idx == 2'd0) && o_out_valid)
        else $error("decoded results not presented");

endmodule
